// ----- hw/rtl/pqts_pkg.sv -----
package pqts_pkg;

    // Field widths fixed by the interface.
    localparam int TASK_W   = 4;
    localparam int PRIO_W   = 8;
    localparam int SLICE_W  = 16;
    localparam int COUNT_W  = 5;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Reset values of the idle task registers.
    localparam logic [TASK_W-1:0]  IDLE_TASK_RST    = 4'd0;
    localparam logic [PRIO_W-1:0]  IDLE_PRIO_RST    = 8'd0;
    localparam logic [SLICE_W-1:0] IDLE_QUANTUM_RST = 16'd10;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_IDLE_TASK    = 2'd0;
    localparam logic [1:0] REG_IDLE_PRIO    = 2'd1;
    localparam logic [1:0] REG_IDLE_QUANTUM = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READY = 2'd1,
        OP_LEAVE = 2'd2,
        OP_NONE  = 2'd3
    } pqts_op_t;

    typedef struct packed {
        pqts_op_t            op;
        logic [TASK_W-1:0]   task_id;
        logic [PRIO_W-1:0]   priority_req;
        logic [SLICE_W-1:0]  quantum;
    } pqts_cmd_t;

    typedef struct packed {
        logic [TASK_W-1:0]   running_task;
        logic [PRIO_W-1:0]   running_priority;
        logic                switched;
        logic [SLICE_W-1:0]  slice_left;
        logic [COUNT_W-1:0]  ready_count;
        logic                dropped;
    } pqts_rsp_t;

    // One ready-queue entry.
    typedef struct packed {
        logic [TASK_W-1:0]   task_id;
        logic [PRIO_W-1:0]   prio;
        logic [SLICE_W-1:0]  slice;
    } qentry_t;

    // What the whole row of queue cells does in one cycle.
    typedef enum logic [1:0] {
        Q_HOLD,
        Q_INSERT,
        Q_POP,
        Q_POP_INSERT
    } qmode_t;

    typedef struct packed {
        qmode_t   mode;
        qentry_t  item;
    } qcmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_REINSERT
    } pqts_state_t;

endpackage

// ----- hw/rtl/priority_quantum_task_scheduler.sv -----
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_ready  pqts_cmd_t (op, task_id, priority_req, quantum)
// rsp       out        rsp_valid / rsp_ready  pqts_rsp_t (one status beat per cmd beat)
// apb       in         psel/penable/pready    idle_task_id, idle_priority, idle_quantum
//
// A command beat is done in ST_IDLE, or passes on to ST_REINSERT when a preemption must put
// the displaced task back into the ready queue; ST_REINSERT is one more shift of the cell row.
// The ready queue is a row of MAX_TASKS cells that insert or pop in a single shift.
// Reset is asynchronous and active low; no clearing pass is needed after it.
// A new command beat is taken only while the response register is empty or being
// drained, so a stalled rsp channel stalls cmd after at most one beat.
module priority_quantum_task_scheduler
    import pqts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  pqts_cmd_t           cmd,

    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pqts_rsp_t           rsp,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int FILL_W = $clog2(MAX_TASKS + 1);

    // Configuration registers.
    logic [TASK_W-1:0]  idle_task_reg,    idle_task_next;
    logic [PRIO_W-1:0]  idle_prio_reg,    idle_prio_next;
    logic [SLICE_W-1:0] idle_quantum_reg, idle_quantum_next;

    // The running task and its slice bookkeeping.
    logic [TASK_W-1:0]  cur_task_reg,  cur_task_next;
    logic [PRIO_W-1:0]  cur_prio_reg,  cur_prio_next;
    logic [SLICE_W-1:0] cur_slice_reg, cur_slice_next;
    logic [SLICE_W-1:0] ticks_reg,     ticks_next;
    logic               idle_run_reg,  idle_run_next;

    logic [FILL_W-1:0]  fill_reg, fill_next;
    pqts_state_t        state_reg, state_next;

    // Holds the task that was displaced until it is put back into the queue.
    qentry_t            save_reg, save_next;

    pqts_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Queue row.
    qcmd_t              qcmd;
    qentry_t            cell_entry [MAX_TASKS];
    logic [MAX_TASKS-1:0] cell_flag;
    logic [MAX_TASKS-1:0] occ;

    logic               fire;
    logic               cfg_write;
    logic               q_empty;
    logic               q_full;
    logic               lands_before;
    logic [SLICE_W-1:0] ticks_dec;
    qentry_t            head;
    qentry_t            new_item;
    qentry_t            cur_item;
    logic               sw;
    logic               drop;
    logic               load_rsp;

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign fire      = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign head      = cell_entry[0];
    assign q_empty   = (fill_reg == '0);
    assign q_full    = (fill_reg == FILL_W'(MAX_TASKS));
    assign ticks_dec = (ticks_reg == '0) ? '0 : ticks_reg - 16'd1;

    assign new_item  = '{task_id: cmd.task_id, prio: cmd.priority_req, slice: cmd.quantum};
    assign cur_item  = '{task_id: cur_task_reg, prio: cur_prio_reg, slice: cur_slice_reg};

    // The new task lands before an existing entry when any occupied cell
    // holds a lower priority than it.
    assign lands_before = |(cell_flag & occ);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            logic    left_flag;
            logic    right_flag;
            qentry_t left_entry;
            qentry_t right_entry;

            assign occ[gi] = (fill_reg > FILL_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left_flag  = 1'b0;
                assign left_entry = cell_entry[gi];
            end
            else
            begin : g_mid_l
                assign left_flag  = cell_flag[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == MAX_TASKS - 1)
            begin : g_last
                assign right_flag  = 1'b1;
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_mid_r
                assign right_flag  = cell_flag[gi+1];
                assign right_entry = cell_entry[gi+1];
            end

            pqts_cell u_cell (
                .clk         (clk),
                .qcmd        (qcmd),
                .occupied    (occ[gi]),
                .left_flag   (left_flag),
                .right_flag  (right_flag),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .flag        (cell_flag[gi])
            );
        end
    endgenerate

    // Next state of the scheduler and the command for the cell row.
    always_comb
    begin
        idle_task_next    = idle_task_reg;
        idle_prio_next    = idle_prio_reg;
        idle_quantum_next = idle_quantum_reg;
        cur_task_next     = cur_task_reg;
        cur_prio_next     = cur_prio_reg;
        cur_slice_next    = cur_slice_reg;
        ticks_next        = ticks_reg;
        idle_run_next     = idle_run_reg;
        fill_next         = fill_reg;
        state_next        = state_reg;
        save_next         = save_reg;
        qcmd.mode         = Q_HOLD;
        qcmd.item         = new_item;
        sw                = 1'b0;
        drop              = 1'b0;
        load_rsp          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    load_rsp = 1'b1;
                    unique case (cmd.op)
                        OP_TICK:
                        begin
                            if ((ticks_dec == '0) ? !q_empty
                                                  : (!q_empty && head.prio > cur_prio_reg))
                            begin
                                if (!idle_run_reg && cur_prio_reg > head.prio)
                                begin
                                    // Expiry, but the running task still ranks first.
                                    ticks_next = cur_slice_reg;
                                end
                                else
                                begin
                                    sw             = 1'b1;
                                    qcmd.mode      = Q_POP;
                                    fill_next      = fill_reg - FILL_W'(1);
                                    cur_task_next  = head.task_id;
                                    cur_prio_next  = head.prio;
                                    cur_slice_next = head.slice;
                                    ticks_next     = head.slice;
                                    idle_run_next  = 1'b0;
                                    if (!idle_run_reg)
                                    begin
                                        save_next  = cur_item;
                                        state_next = ST_REINSERT;
                                        load_rsp   = 1'b0;
                                    end
                                end
                            end
                            else if (ticks_dec == '0)
                            begin
                                ticks_next = cur_slice_reg;
                            end
                            else
                            begin
                                ticks_next = ticks_dec;
                            end
                        end
                        OP_READY:
                        begin
                            if (q_full)
                            begin
                                drop = 1'b1;
                            end
                            else if (lands_before && cmd.priority_req > cur_prio_reg)
                            begin
                                sw            = 1'b1;
                                idle_run_next = 1'b0;
                                if (cell_flag[0])
                                begin
                                    // The new task would be the head: run it directly.
                                    cur_task_next  = new_item.task_id;
                                    cur_prio_next  = new_item.prio;
                                    cur_slice_next = new_item.slice;
                                    ticks_next     = new_item.slice;
                                end
                                else
                                begin
                                    qcmd.mode      = Q_POP_INSERT;
                                    cur_task_next  = head.task_id;
                                    cur_prio_next  = head.prio;
                                    cur_slice_next = head.slice;
                                    ticks_next     = head.slice;
                                end
                                if (!idle_run_reg)
                                begin
                                    save_next  = cur_item;
                                    state_next = ST_REINSERT;
                                    load_rsp   = 1'b0;
                                end
                            end
                            else
                            begin
                                qcmd.mode = Q_INSERT;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        OP_LEAVE:
                        begin
                            sw = 1'b1;
                            if (!q_empty)
                            begin
                                qcmd.mode      = Q_POP;
                                fill_next      = fill_reg - FILL_W'(1);
                                cur_task_next  = head.task_id;
                                cur_prio_next  = head.prio;
                                cur_slice_next = head.slice;
                                ticks_next     = head.slice;
                                idle_run_next  = 1'b0;
                            end
                            else
                            begin
                                cur_task_next  = idle_task_reg;
                                cur_prio_next  = idle_prio_reg;
                                cur_slice_next = idle_quantum_reg;
                                ticks_next     = idle_quantum_reg;
                                idle_run_next  = 1'b1;
                            end
                        end
                        OP_NONE:
                        begin
                            sw = 1'b0;
                        end
                        default:
                        begin
                            sw = 1'b0;
                        end
                    endcase
                end
            end
            ST_REINSERT:
            begin
                // Put the displaced task back; the queue has room, as it was not full or its head was popped.
                qcmd.mode  = Q_INSERT;
                qcmd.item  = save_reg;
                fill_next  = fill_reg + FILL_W'(1);
                sw         = 1'b1;
                load_rsp   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must make configuration writes only while no command is in flight; the block does not enforce this.
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_IDLE_TASK:
                begin
                    idle_task_next = pwdata[TASK_W-1:0];
                    if (idle_run_reg)
                    begin
                        cur_task_next = pwdata[TASK_W-1:0];
                    end
                end
                REG_IDLE_PRIO:
                begin
                    idle_prio_next = pwdata[PRIO_W-1:0];
                    if (idle_run_reg)
                    begin
                        cur_prio_next = pwdata[PRIO_W-1:0];
                    end
                end
                REG_IDLE_QUANTUM:
                begin
                    idle_quantum_next = pwdata[SLICE_W-1:0];
                    if (idle_run_reg)
                    begin
                        cur_slice_next = pwdata[SLICE_W-1:0];
                    end
                end
                default:
                begin
                    idle_task_next = idle_task_reg;
                end
            endcase
        end

        rsp_next.running_task     = cur_task_next;
        rsp_next.running_priority = cur_prio_next;
        rsp_next.switched         = sw;
        rsp_next.slice_left       = ticks_next;
        rsp_next.ready_count      = COUNT_W'(fill_next);
        rsp_next.dropped          = drop;

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IDLE_TASK:    prdata = APB_DW'(idle_task_reg);
            REG_IDLE_PRIO:    prdata = APB_DW'(idle_prio_reg);
            REG_IDLE_QUANTUM: prdata = APB_DW'(idle_quantum_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_task_reg    <= IDLE_TASK_RST;
            idle_prio_reg    <= IDLE_PRIO_RST;
            idle_quantum_reg <= IDLE_QUANTUM_RST;
            cur_task_reg     <= IDLE_TASK_RST;
            cur_prio_reg     <= IDLE_PRIO_RST;
            cur_slice_reg    <= IDLE_QUANTUM_RST;
            ticks_reg        <= IDLE_QUANTUM_RST;
            idle_run_reg     <= 1'b1;
            fill_reg         <= '0;
            state_reg        <= ST_IDLE;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            idle_task_reg    <= idle_task_next;
            idle_prio_reg    <= idle_prio_next;
            idle_quantum_reg <= idle_quantum_next;
            cur_task_reg     <= cur_task_next;
            cur_prio_reg     <= cur_prio_next;
            cur_slice_reg    <= cur_slice_next;
            ticks_reg        <= ticks_next;
            idle_run_reg     <= idle_run_next;
            fill_reg         <= fill_next;
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        save_reg <= save_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- hw/rtl/pqts_cell.sv -----
module pqts_cell
    import pqts_pkg::*;
(
    input  logic    clk,
    input  qcmd_t   qcmd,
    input  logic    occupied,
    input  logic    left_flag,
    input  logic    right_flag,
    input  qentry_t left_entry,
    input  qentry_t right_entry,
    output qentry_t entry,
    output logic    flag
);

    qentry_t entry_reg;
    qentry_t entry_next;

    // The broadcast item belongs at or before this slot when the slot is empty
    // or holds a strictly lower priority. Along the sorted row this is monotone.
    assign flag  = !occupied || (qcmd.item.prio > entry_reg.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (qcmd.mode)
            Q_HOLD:
            begin
                entry_next = entry_reg;
            end
            Q_INSERT:
            begin
                if (left_flag)
                begin
                    entry_next = left_entry;
                end
                else if (flag)
                begin
                    entry_next = qcmd.item;
                end
            end
            Q_POP:
            begin
                entry_next = right_entry;
            end
            Q_POP_INSERT:
            begin
                // The head leaves and the item goes in, all in one shift.
                if (flag)
                begin
                    entry_next = entry_reg;
                end
                else if (right_flag)
                begin
                    entry_next = qcmd.item;
                end
                else
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hw/rtl/pqts_checker.sv -----
module pqts_checker
    import pqts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input pqts_rsp_t rsp
);

    // A stalled response beat holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // No command is taken while a finished response waits.
    a_cmd_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("command taken while response stalled");

    // A refused insertion never switches tasks.
    a_drop_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.dropped |-> !rsp.switched)
        else $error("dropped beat also reports a switch");

    // Insertions are refused only when the queue is full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.dropped |-> rsp.ready_count == COUNT_W'(MAX_TASKS))
        else $error("insertion dropped with room in the queue");

endmodule

bind priority_quantum_task_scheduler pqts_checker #(.MAX_TASKS(MAX_TASKS)) u_pqts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- sim/tb_top.sv -----
module tb_top;
    import pqts_pkg::*;

    // Depth of the ready queue in the block under test. The checker keeps its
    // own copy of the queue at the same depth.
    localparam int QDEPTH = 16;

    // Number of register settings that the random part walks through, and the
    // random command beats issued under each of them.
    localparam int NPHASE = 10;
    localparam int RAND_PER_PHASE = 85;

    // Stalls of the receiver and gaps on the sender are drawn from bounded random
    // ranges below this limit, so this many quiet cycles in a row can only mean a hang.
    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cmd_valid = 1'b0;
    logic cmd_ready;
    pqts_cmd_t cmd = '0;

    logic rsp_valid;
    logic rsp_ready = 1'b0;
    pqts_rsp_t rsp;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    priority_quantum_task_scheduler #(
        .MAX_TASKS (QDEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow state.
    //
    // The checker tracks the ready queue, the running task and the idle
    // registers on its own. It is advanced once per accepted command beat,
    // and the status beat that the block must return for that command is
    // computed right there. Register writes only happen while the block has
    // nothing in flight, so updating the shadow registers at the write edge
    // keeps both views in step.
    // ------------------------------------------------------------------
    logic [TASK_W-1:0]  rq_task  [QDEPTH];
    logic [PRIO_W-1:0]  rq_prio  [QDEPTH];
    logic [SLICE_W-1:0] rq_slice [QDEPTH];
    int unsigned        rq_fill = 0;

    logic [TASK_W-1:0]  run_task  = IDLE_TASK_RST;
    logic [PRIO_W-1:0]  run_prio  = IDLE_PRIO_RST;
    logic [SLICE_W-1:0] run_slice = IDLE_QUANTUM_RST;
    logic [SLICE_W-1:0] run_left  = IDLE_QUANTUM_RST;
    logic               idle_on   = 1'b1;

    logic [TASK_W-1:0]  idle_tid   = IDLE_TASK_RST;
    logic [PRIO_W-1:0]  idle_prio  = IDLE_PRIO_RST;
    logic [SLICE_W-1:0] idle_slice = IDLE_QUANTUM_RST;

    // Sorted insert: a new entry goes behind every entry of equal or higher
    // priority. Returns the slot it landed in, or QDEPTH when it was refused.
    function automatic int unsigned rq_insert(logic [TASK_W-1:0] t, logic [PRIO_W-1:0] p,
                                              logic [SLICE_W-1:0] s);
        int unsigned pos;
        int unsigned i;
        pos = 0;
        if (rq_fill >= QDEPTH)
            return QDEPTH;
        while (pos < rq_fill && !(p > rq_prio[pos]))
            pos++;
        for (i = rq_fill; i > pos; i--)
        begin
            rq_task[i]  = rq_task[i-1];
            rq_prio[i]  = rq_prio[i-1];
            rq_slice[i] = rq_slice[i-1];
        end
        rq_task[pos]  = t;
        rq_prio[pos]  = p;
        rq_slice[pos] = s;
        rq_fill++;
        return pos;
    endfunction

    // Start the queue head, or the idle task when nothing is waiting.
    function automatic void run_head();
        int unsigned i;
        if (rq_fill > 0)
        begin
            run_task  = rq_task[0];
            run_prio  = rq_prio[0];
            run_slice = rq_slice[0];
            for (i = 1; i < rq_fill; i++)
            begin
                rq_task[i-1]  = rq_task[i];
                rq_prio[i-1]  = rq_prio[i];
                rq_slice[i-1] = rq_slice[i];
            end
            rq_fill--;
            idle_on = 1'b0;
        end
        else
        begin
            run_task  = idle_tid;
            run_prio  = idle_prio;
            run_slice = idle_slice;
            idle_on   = 1'b1;
        end
        run_left = run_slice;
    endfunction

    // Hand the CPU to the queue head and put the old task back in line. When
    // the running task would land in front anyway, it simply keeps going with
    // a fresh slice. The head leaves before the reinsert, so a full queue
    // never loses the displaced task. The idle task is never queued.
    function automatic logic yield_to_head();
        logic [TASK_W-1:0]  t;
        logic [PRIO_W-1:0]  p;
        logic [SLICE_W-1:0] s;
        logic               was_idle;
        t = run_task;
        p = run_prio;
        s = run_slice;
        was_idle = idle_on;
        if (rq_fill == 0 || (!was_idle && p > rq_prio[0]))
        begin
            run_left = run_slice;
            return 1'b0;
        end
        run_head();
        if (!was_idle)
            void'(rq_insert(t, p, s));
        return 1'b1;
    endfunction

    // Advance the shadow scheduler by one command and return the status beat
    // that the block owes for it.
    function automatic pqts_rsp_t next_status(pqts_cmd_t c);
        pqts_rsp_t   r;
        int unsigned pos;
        int unsigned old_fill;
        logic        sw;
        logic        drop;
        sw = 1'b0;
        drop = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                // The count saturates at zero, so a zero slice expires on
                // every tick.
                if (run_left > 0)
                    run_left--;
                if (run_left == 0)
                begin
                    if (rq_fill > 0)
                        sw = yield_to_head();
                    else
                        run_left = run_slice;
                end
                else if (rq_fill > 0 && rq_prio[0] > run_prio)
                begin
                    sw = yield_to_head();
                end
            end
            OP_READY:
            begin
                // Only a task that jumps ahead of an existing entry may
                // preempt; a lone entry in an empty queue waits for a tick.
                old_fill = rq_fill;
                pos = rq_insert(c.task_id, c.priority_req, c.quantum);
                if (pos >= QDEPTH)
                    drop = 1'b1;
                else if (pos < old_fill && c.priority_req > run_prio)
                    sw = yield_to_head();
            end
            OP_LEAVE:
            begin
                run_head();
                sw = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.running_task     = run_task;
        r.running_priority = run_prio;
        r.switched         = sw;
        r.slice_left       = run_left;
        r.ready_count      = COUNT_W'(rq_fill);
        r.dropped          = drop;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by the driver, the monitor and the sequencer.
    // ------------------------------------------------------------------
    pqts_cmd_t   cmd_backlog[$];
    pqts_rsp_t   status_due[$];
    int unsigned cmds_queued = 0;
    int unsigned statuses_seen = 0;
    int unsigned mismatches = 0;
    int unsigned switch_cnt = 0;
    int unsigned drop_cnt = 0;
    int unsigned full_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned settings_used = 1;
    logic        cmd_taken = 1'b0;

    // Pacing styles: 0 runs flat out, 1 idles lightly, 2 idles heavily.
    int unsigned sender_style = 1;
    int unsigned rsp_style = 1;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;

    function automatic pqts_cmd_t make_cmd(pqts_op_t op, logic [TASK_W-1:0] t,
                                           logic [PRIO_W-1:0] p, logic [SLICE_W-1:0] q);
        pqts_cmd_t c;
        c.op = op;
        c.task_id = t;
        c.priority_req = p;
        c.quantum = q;
        return c;
    endfunction

    function automatic void push_cmd(pqts_cmd_t c);
        cmd_backlog.push_back(c);
        cmds_queued++;
    endfunction

    // Random command. Priorities mostly come from a coarse set so that ties,
    // and with them first-in first-out order, show up often; slices are
    // mostly short so that expiry happens regularly.
    function automatic pqts_cmd_t rand_cmd(int unsigned ready_pct, int unsigned leave_pct);
        pqts_cmd_t   c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        c.task_id = TASK_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0:       c.priority_req = 8'd0;
            1:       c.priority_req = 8'd255;
            2, 3, 4, 5, 6:
                     c.priority_req = PRIO_W'($urandom_range(0, 3) * 64);
            default: c.priority_req = PRIO_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            6:       c.quantum = 16'd0;
            7:       c.quantum = 16'hFFFF;
            8, 9:    c.quantum = SLICE_W'($urandom_range(0, 65535));
            default: c.quantum = SLICE_W'($urandom_range(1, 4));
        endcase
        if (roll < 4)
            c.op = OP_NONE;
        else if (roll < 4 + ready_pct)
            c.op = OP_READY;
        else if (roll < 4 + ready_pct + leave_pct)
            c.op = OP_LEAVE;
        else
            c.op = OP_TICK;
        return c;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver. Feeds command beats from the backlog in bursts separated by
    // random gaps. A new beat is put up only once the previous one was
    // taken, and the payload holds still while valid waits for ready.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                cmd <= cmd_backlog.pop_front();
                cmd_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    case (sender_style)
                        0:
                        begin
                            burst_left = $urandom_range(8, 32);
                            gap_left = 0;
                        end
                        1:
                        begin
                            burst_left = $urandom_range(1, 8);
                            gap_left = $urandom_range(0, 3);
                        end
                        default:
                        begin
                            burst_left = $urandom_range(1, 4);
                            gap_left = $urandom_range(1, 12);
                        end
                    endcase
                end
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Receiver. Alternates runs of ready with stalls whose lengths depend on
    // the current style; style 0 never stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_style == 0)
            begin
                rsp_ready <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (rsp_ready)
            begin
                rsp_ready <= 1'b0;
                hold_left = (rsp_style == 1) ? $urandom_range(0, 3) : $urandom_range(1, 15);
            end
            else
            begin
                rsp_ready <= 1'b1;
                hold_left = (rsp_style == 1) ? $urandom_range(0, 8) : $urandom_range(0, 4);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. On each rising edge it records an accepted command beat into
    // the shadow scheduler and checks an accepted status beat, field by
    // field, against the oldest outstanding expectation. It also runs the
    // watchdog on cycles in which neither channel moves a beat.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pqts_rsp_t want;
        if (rst_n)
        begin
            cmd_taken = cmd_valid && cmd_ready;
            if (cmd_taken)
                status_due.push_back(next_status(cmd));
            if (rsp_valid && rsp_ready)
            begin
                statuses_seen++;
                if (status_due.size() == 0)
                begin
                    $error("status beat arrived with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    switch_cnt += 32'(want.switched);
                    drop_cnt += 32'(want.dropped);
                    if (want.ready_count == COUNT_W'(QDEPTH))
                        full_cnt++;
                    check_field("running_task", 32'(want.running_task),
                                32'(rsp.running_task));
                    check_field("running_priority", 32'(want.running_priority),
                                32'(rsp.running_priority));
                    check_field("switched", 32'(want.switched), 32'(rsp.switched));
                    check_field("slice_left", 32'(want.slice_left), 32'(rsp.slice_left));
                    check_field("ready_count", 32'(want.ready_count), 32'(rsp.ready_count));
                    check_field("dropped", 32'(want.dropped), 32'(rsp.dropped));
                end
            end
            if (cmd_taken || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles, %0d statuses still due",
                         QUIET_LIMIT, cmds_queued - statuses_seen);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Write one idle register over the configuration port, then read it back.
    // The shadow copy is updated at the write edge. While the idle task runs,
    // its identity, priority and slice follow the register, but the ticks
    // already counted down are kept.
    task automatic write_idle_reg(logic [1:0] idx, logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] back;
        case (idx)
            REG_IDLE_TASK: mask = 32'h0000_000F;
            REG_IDLE_PRIO: mask = 32'h0000_00FF;
            default:       mask = 32'h0000_FFFF;
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_IDLE_TASK:
            begin
                idle_tid = val[TASK_W-1:0];
                if (idle_on)
                    run_task = idle_tid;
            end
            REG_IDLE_PRIO:
            begin
                idle_prio = val[PRIO_W-1:0];
                if (idle_on)
                    run_prio = idle_prio;
            end
            default:
            begin
                idle_slice = val[SLICE_W-1:0];
                if (idle_on)
                    run_slice = idle_slice;
            end
        endcase
        // Back-to-back read of the same register: setup, then access.
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        back = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if ((back & mask) !== (val & mask))
        begin
            $error("register %0d readback: expected %0d, got %0d", idx, val & mask,
                   back & mask);
            mismatches++;
        end
    endtask

    // Block until every queued command has produced its status beat, then let
    // the block settle before touching registers.
    task automatic drain();
        while (statuses_seen < cmds_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, a directed walk through the corner cases under the
    // reset settings, then random phases under changing idle registers.
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int unsigned phase;
        int unsigned n;
        int unsigned ready_pct;
        int unsigned leave_pct;
        logic [31:0] cfg_tid;
        logic [31:0] cfg_prio;
        logic [31:0] cfg_slice;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk. The idle task (id 0, priority 0, slice 10) runs.
        push_cmd(make_cmd(OP_NONE, 4'd9, 8'd77, 16'd5));      // unused op does nothing
        push_cmd(make_cmd(OP_LEAVE, 4'd0, 8'd0, 16'd0));      // leave on empty: idle again
        push_cmd(make_cmd(OP_READY, 4'd5, 8'd100, 16'd3));    // empty queue: no preemption
        push_cmd(make_cmd(OP_READY, 4'd7, 8'd255, 16'hFFFF)); // jumps ahead, idle is displaced
        push_cmd(make_cmd(OP_READY, 4'd6, 8'd200, 16'd1));    // ahead of 5 but below 7
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));       // plain count down
        push_cmd(make_cmd(OP_LEAVE, 4'd0, 8'd0, 16'd0));      // 6 starts with a one-tick slice
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));       // expiry, but 6 outranks the head
        push_cmd(make_cmd(OP_READY, 4'd8, 8'd0, 16'd0));      // zero slice, queued at the tail
        push_cmd(make_cmd(OP_LEAVE, 4'd0, 8'd0, 16'd0));      // 5 runs
        push_cmd(make_cmd(OP_LEAVE, 4'd0, 8'd0, 16'd0));      // 8 runs with nothing left
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));       // saturates, reloads zero
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));
        push_cmd(make_cmd(OP_READY, 4'd15, 8'd50, 16'd2));    // outranks 8, still no preemption
        // Fill the queue with equal-priority duplicates, including the
        // running task's own id, then offer one urgent task too many.
        for (n = 0; n < QDEPTH - 1; n++)
            push_cmd(make_cmd(OP_READY, TASK_W'(n % 3 == 0 ? 8 : n), 8'd0,
                              SLICE_W'(n % 4 + 1)));
        push_cmd(make_cmd(OP_READY, 4'd3, 8'd255, 16'd9));    // refused: queue full
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));       // preemption with a full queue
        push_cmd(make_cmd(OP_TICK, 4'd0, 8'd0, 16'd0));
        drain();

        for (phase = 1; phase <= NPHASE; phase++)
        begin
            // First settings hit the extremes, the rest are random.
            case (phase)
                1:
                begin
                    cfg_tid = 15;
                    cfg_prio = 255;
                    cfg_slice = 65535;
                end
                2:
                begin
                    cfg_tid = 0;
                    cfg_prio = 0;
                    cfg_slice = 1;
                end
                3:
                begin
                    cfg_tid = 15;
                    cfg_prio = 0;
                    cfg_slice = 65535;
                end
                default:
                begin
                    cfg_tid = $urandom_range(0, 15);
                    cfg_prio = $urandom_range(0, 255);
                    cfg_slice = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 65535);
                end
            endcase
            write_idle_reg(REG_IDLE_TASK, cfg_tid);
            write_idle_reg(REG_IDLE_PRIO, cfg_prio);
            write_idle_reg(REG_IDLE_QUANTUM, cfg_slice);
            settings_used++;

            // Pacing rotates so that flat-out stretches, light and heavy
            // idling on either side, and mixes of them all occur.
            sender_style = phase % 3;
            rsp_style = (phase * 2) % 3;

            // The mix of readies and leaves decides whether the queue tends
            // to sit near full, near empty, or wander in between.
            case (phase % 4)
                0:
                begin
                    ready_pct = 25;
                    leave_pct = 25;
                end
                1:
                begin
                    ready_pct = 60;
                    leave_pct = 8;
                end
                2:
                begin
                    ready_pct = 40;
                    leave_pct = 15;
                end
                default:
                begin
                    ready_pct = 30;
                    leave_pct = 30;
                end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++)
                push_cmd(rand_cmd(ready_pct, leave_pct));

            // Every other phase ends by emptying the queue so that the next
            // register writes land while the idle task runs.
            if (phase % 2 == 1)
            begin
                for (n = 0; n <= QDEPTH; n++)
                    push_cmd(make_cmd(OP_LEAVE, TASK_W'($urandom_range(0, 15)),
                                      PRIO_W'($urandom_range(0, 255)),
                                      SLICE_W'($urandom_range(0, 65535))));
            end
            drain();
        end

        repeat (8) @(negedge clk);
        if (status_due.size() != 0)
        begin
            $error("%0d status beats never arrived", status_due.size());
            mismatches++;
        end

        $display("Ran %0d scheduler commands under %0d idle-register settings.",
                 cmds_queued, settings_used);
        $display("Saw %0d task switches, %0d refused insertions, %0d beats with a full queue.",
                 switch_cnt, drop_cnt, full_cnt);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
